[hdl/rtwa_pkg.sv]
package rtwa_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [15:0] MAX_AGE_RST = 16'd300;

  // request kinds
  localparam logic KIND_LEARN  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // result status codes
  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_NONE     = 3'd1;
  localparam logic [2:0] ST_STALE    = 3'd2;
  localparam logic [2:0] ST_REPLACED = 3'd3;
  localparam logic [2:0] ST_KEPT     = 3'd4;
  localparam logic [2:0] ST_INSERTED = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;

  typedef struct packed {
    logic [31:0] addr;
    logic [47:0] mac;
    logic [7:0]  iface;
    logic [7:0]  hops;
    logic [31:0] stamp;
  } row_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic resolve;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic more;
    logic pend;
    logic hit;
  } sts_t;

endpackage

[hdl/rtwa_ctrl.sv]
module rtwa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rtwa_pkg::sts_t sts,
  output rtwa_pkg::cmd_t cmd,
  output logic           busy
);
  import rtwa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // stop on first match, or once every used slot has been compared
          if (sts.hit || (!sts.pend && !sts.more)) begin
            state <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd.load    = (state == S_IDLE) && start;
    cmd.scan    = (state == S_SCAN);
    cmd.resolve = (state == S_RESOLVE);
  end

  assign busy = (state != S_IDLE);

endmodule

[hdl/rtwa_dpath.sv]
module rtwa_dpath (
  input  logic           clk,
  input  logic           rst,
  input  rtwa_pkg::cmd_t cmd,
  output rtwa_pkg::sts_t sts,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_data,
  input  logic           kind,
  input  logic [31:0]    dest_addr,
  input  logic [47:0]    next_hop_mac,
  input  logic [7:0]     iface_index,
  input  logic [7:0]     hop_count,
  input  logic [31:0]    now_seconds,
  output logic           done,
  output logic [2:0]     status,
  output logic [5:0]     entry_index,
  output logic [47:0]    route_mac,
  output logic [7:0]     route_iface,
  output logic [7:0]     route_hops
);
  import rtwa_pkg::*;

  // route table storage
  row_t mem [MAX_ENTRIES];
  row_t rd_row;

  logic [MAX_ENTRIES-1:0] usable;
  logic [CNT_W-1:0]       used;
  logic [15:0]            max_age;

  // latched request
  logic        req_kind;
  logic [31:0] req_addr;
  logic [47:0] req_mac;
  logic [7:0]  req_iface;
  logic [7:0]  req_hops;
  logic [31:0] req_now;

  // scan pipeline
  logic [CNT_W-1:0] rd_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_vld;
  logic             found;

  logic hit;
  logic more;
  logic issue;

  // resolve
  logic             slot_usable;
  logic [31:0]      age;
  logic             fresh;
  logic [2:0]       res_status;
  logic [IDX_W-1:0] res_slot;
  logic [47:0]      res_mac;
  logic [7:0]       res_iface;
  logic [7:0]       res_hops;
  logic             mem_we;
  logic [IDX_W-1:0] wr_idx;
  logic             set_use;
  logic             clr_use;
  logic             bump;
  row_t             wr_row;

  assign hit   = cmp_vld && (rd_row.addr == req_addr);
  assign more  = (rd_idx < used);
  assign issue = cmd.scan && more && !hit;

  always_comb begin
    sts.more = more;
    sts.pend = cmp_vld;
    sts.hit  = hit;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind  <= kind;
      req_addr  <= dest_addr;
      req_mac   <= next_hop_mac;
      req_iface <= iface_index;
      req_hops  <= hop_count;
      req_now   <= now_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_row;
    end else if (issue) begin
      rd_row <= mem[rd_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_idx <= rd_idx[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      usable  <= '0;
      max_age <= MAX_AGE_RST;
      done    <= 1'b0;
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
      found   <= 1'b0;
    end else begin
      done <= cmd.resolve;
      if (cfg_we) begin
        max_age <= cfg_data;
      end
      if (cmd.load) begin
        rd_idx  <= '0;
        cmp_vld <= 1'b0;
        found   <= 1'b0;
      end else if (cmd.scan) begin
        cmp_vld <= issue;
        if (hit) begin
          found <= 1'b1;
        end
        if (issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
      if (set_use) begin
        usable[wr_idx] <= 1'b1;
      end else if (clr_use) begin
        usable[wr_idx] <= 1'b0;
      end
      if (bump) begin
        used <= used + 1'b1;
      end
    end
  end

  assign slot_usable = usable[cmp_idx];
  assign age         = req_now - rd_row.stamp;
  assign fresh       = (age < 32'(max_age));

  always_comb begin
    wr_row.addr  = req_addr;
    wr_row.mac   = req_mac;
    wr_row.iface = req_iface;
    wr_row.hops  = req_hops;
    wr_row.stamp = req_now;
  end

  always_comb begin
    res_status = ST_NONE;
    res_slot   = '0;
    res_mac    = '0;
    res_iface  = '0;
    res_hops   = '0;
    mem_we     = 1'b0;
    wr_idx     = cmp_idx;
    set_use    = 1'b0;
    clr_use    = 1'b0;
    bump       = 1'b0;
    if (cmd.resolve) begin
      if (req_kind == KIND_LEARN) begin
        if (found) begin
          res_slot = cmp_idx;
          if (!slot_usable || (rd_row.hops > req_hops)) begin
            res_status = ST_REPLACED;
            mem_we     = 1'b1;
            set_use    = 1'b1;
          end else begin
            res_status = ST_KEPT;
          end
        end else if (used < CNT_W'(MAX_ENTRIES)) begin
          res_status = ST_INSERTED;
          res_slot   = used[IDX_W-1:0];
          wr_idx     = used[IDX_W-1:0];
          mem_we     = 1'b1;
          set_use    = 1'b1;
          bump       = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end else begin
        if (found && slot_usable) begin
          res_slot = cmp_idx;
          if (fresh) begin
            res_status = ST_HIT;
            res_mac    = rd_row.mac;
            res_iface  = rd_row.iface;
            res_hops   = rd_row.hops;
          end else begin
            res_status = ST_STALE;
            clr_use    = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      status      <= res_status;
      entry_index <= 6'(res_slot);
      route_mac   <= res_mac;
      route_iface <= res_iface;
      route_hops  <= res_hops;
    end
  end

endmodule

[hdl/route_table_with_aging.sv]
// Route table with aging. A request is taken when start is high and busy is
// low; kind selects learn (0) or lookup (1). Exactly one result follows per
// request, shown for one cycle with done high; the receiver cannot stall it,
// so it must sample status and the route fields in that cycle. The scan reads
// one table row per cycle from a single-port memory into a register and
// compares it with the key; it stops on the first match or once every used
// slot has been compared, then the resolve state decides and writes back.
// busy drops in the cycle done is shown, so the next request may be issued
// then. max_age (reset 300) is written over the cfg channel, which is always
// ready; write it only while busy is low.
module route_table_with_aging (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [31:0] dest_addr,
  input  logic [47:0] next_hop_mac,
  input  logic [7:0]  iface_index,
  input  logic [7:0]  hop_count,
  input  logic [31:0] now_seconds,
  // result
  output logic        done,
  output logic [2:0]  status,
  output logic [5:0]  entry_index,
  output logic [47:0] route_mac,
  output logic [7:0]  route_iface,
  output logic [7:0]  route_hops,
  // max_age register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import rtwa_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic accept;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // sequencing: idle -> scan (one row per cycle) -> resolve -> idle
  rtwa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // table memory, usable flags, fill count, compare and update logic
  rtwa_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .kind         (kind),
    .dest_addr    (dest_addr),
    .next_hop_mac (next_hop_mac),
    .iface_index  (iface_index),
    .hop_count    (hop_count),
    .now_seconds  (now_seconds),
    .done         (done),
    .status       (status),
    .entry_index  (entry_index),
    .route_mac    (route_mac),
    .route_iface  (route_iface),
    .route_hops   (route_hops)
  );

  // a result only follows a request in flight
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in flight");

  // finishing a request always shows a result
  a_busy_end_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("request finished without a result");

  // route fields are zero unless fresh hit
  a_route_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_HIT)) |->
      (route_mac == '0) && (route_iface == '0) && (route_hops == '0))
    else $error("route fields set on a non-hit result");

  // no-route and full carry slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (done && ((status == ST_NONE) || (status == ST_FULL))) |-> (entry_index == '0))
    else $error("slot reported on a miss or full result");

endmodule
